[rtl/bary_pkg.sv]
package bary_pkg;

    localparam int COORD_WIDTH          = 24;
    localparam int WEIGHT_WIDTH         = 32;
    localparam int WEIGHT_FRAC_BITS_DEF = 28;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [WEIGHT_WIDTH-1:0]       weight_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t az;
        coord_t bx;
        coord_t by;
        coord_t bz;
        coord_t cx;
        coord_t cy;
        coord_t cz;
        coord_t px;
        coord_t py;
        coord_t pz;
    } req_t;

    typedef struct packed {
        weight_t weight_a;
        weight_t weight_b;
        weight_t weight_c;
        logic    degenerate;
    } res_t;

endpackage

[rtl/barycentric_by_heron_areas.sv]
// channel   signals                 handshake
// -------   ---------------------   ----------------------------------------
// request   start, busy, request    taken at a rising edge with start high, busy low
// result    done, result            done high for one cycle, result valid with it
//
// fully pipelined: one request per clock, busy is always low.
// pipeline: 8 front stages (input, differences, cross products,
// squares, norms, range check), 64 divider stages, 32 square root stages,
// one output register.
// rst_n clears the valid bits only; data registers are not reset.
// the receiver cannot stall, so no back pressure exists anywhere.
module barycentric_by_heron_areas #(
    parameter int WEIGHT_FRAC_BITS = bary_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  bary_pkg::req_t  request,
    output logic            done,
    output bary_pkg::res_t  result
);

    localparam int CW = bary_pkg::COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;
    localparam int AW = 2 * CW + 1;
    localparam int LW = 32;
    localparam int HW = AW - LW;
    localparam int NW = 2 * AW + 2;
    localparam int WW = bary_pkg::WEIGHT_WIDTH;
    localparam int QW = 2 * WW;
    localparam int SH = QW - 2 * WEIGHT_FRAC_BITS;
    localparam int SW = WW + 1;
    localparam int FS = 8;

    // cross products: total, then sub areas opposite a, b, c
    localparam int U_SEL [4] = '{0, 3, 1, 0};
    localparam int V_SEL [4] = '{1, 4, 2, 2};

    logic [FS-1:0]            fv_reg, fv_next;
    bary_pkg::req_t           in_reg;
    logic signed [DW-1:0]     dif_reg [5][3];
    logic signed [DW-1:0]     dif_next [5][3];
    logic signed [PW-1:0]     prd_reg [4][3][2];
    logic signed [PW-1:0]     prd_next [4][3][2];
    logic [AW-1:0]            abs_reg [4][3];
    logic [AW-1:0]            abs_next [4][3];
    logic [2*HW-1:0]          phh_reg [4][3];
    logic [2*HW-1:0]          phh_next [4][3];
    logic [HW+LW-1:0]         phl_reg [4][3];
    logic [HW+LW-1:0]         phl_next [4][3];
    logic [2*LW-1:0]          pll_reg [4][3];
    logic [2*LW-1:0]          pll_next [4][3];
    logic [2*AW-1:0]          sq_reg [4][3];
    logic [2*AW-1:0]          sq_next [4][3];
    logic [NW-1:0]            nrm_reg [4];
    logic [NW-1:0]            nrm_next [4];

    logic [NW-1:0]            r0_reg [3];
    logic [NW-1:0]            r0_next [3];
    logic [QW-1:0]            q0_reg [3];
    logic [QW-1:0]            q0_next [3];
    logic [2:0]               ov0_reg, ov0_next;
    logic [NW-1:0]            nt0_reg, nt0_next;
    logic                     deg0_reg, deg0_next;

    logic [QW-1:0]            dv_vld_reg, dv_vld_next;
    logic [NW-1:0]            dv_rem_reg [QW][3];
    logic [NW-1:0]            dv_rem_next [QW][3];
    logic [QW-1:0]            dv_qx_reg [QW][3];
    logic [QW-1:0]            dv_qx_next [QW][3];
    logic [NW-1:0]            dv_nt_reg [QW];
    logic [NW-1:0]            dv_nt_next [QW];
    logic [2:0]               dv_ov_reg [QW];
    logic [2:0]               dv_ov_next [QW];
    logic [QW-1:0]            dv_deg_reg, dv_deg_next;

    logic [WW-1:0]            sr_vld_reg, sr_vld_next;
    logic [SW-1:0]            sr_rem_reg [WW][3];
    logic [SW-1:0]            sr_rem_next [WW][3];
    logic [WW-1:0]            sr_root_reg [WW][3];
    logic [WW-1:0]            sr_root_next [WW][3];
    logic [QW-1:0]            sr_q_reg [WW][3];
    logic [QW-1:0]            sr_q_next [WW][3];
    logic [2:0]               sr_ov_reg [WW];
    logic [2:0]               sr_ov_next [WW];
    logic [WW-1:0]            sr_deg_reg, sr_deg_next;

    logic                     done_reg, done_next;
    bary_pkg::res_t           result_reg, result_next;

    always_comb
    begin
        bary_pkg::coord_t     vt [4][3];
        logic signed [XW-1:0] cdf;
        logic [HW-1:0]        hi;
        logic [LW-1:0]        lo;
        logic [NW+SH-1:0]     ntsh;
        logic [NW+SH-1:0]     nsx;
        logic [NW-1:0]        rin;
        logic [QW-1:0]        qin;
        logic [NW-1:0]        ntin;
        logic [NW:0]          dr;
        logic                 ge;
        logic [SW-1:0]        sin;
        logic [WW-1:0]        root;
        logic [SW+1:0]        r2;
        logic [SW+1:0]        tr;
        bary_pkg::weight_t    w [3];

        vt[0] = '{in_reg.ax, in_reg.ay, in_reg.az};
        vt[1] = '{in_reg.bx, in_reg.by, in_reg.bz};
        vt[2] = '{in_reg.cx, in_reg.cy, in_reg.cz};
        vt[3] = '{in_reg.px, in_reg.py, in_reg.pz};

        fv_next = {fv_reg[FS-2:0], start};

        // edge vectors: b-a, c-a, p-a, c-b, p-b
        for (int j = 0; j < 3; j++)
        begin
            dif_next[0][j] = DW'(vt[1][j]) - DW'(vt[0][j]);
            dif_next[1][j] = DW'(vt[2][j]) - DW'(vt[0][j]);
            dif_next[2][j] = DW'(vt[3][j]) - DW'(vt[0][j]);
            dif_next[3][j] = DW'(vt[2][j]) - DW'(vt[1][j]);
            dif_next[4][j] = DW'(vt[3][j]) - DW'(vt[1][j]);
        end

        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prd_next[k][j][0] = PW'(dif_reg[U_SEL[k]][(j+1)%3])
                                  * PW'(dif_reg[V_SEL[k]][(j+2)%3]);
                prd_next[k][j][1] = PW'(dif_reg[U_SEL[k]][(j+2)%3])
                                  * PW'(dif_reg[V_SEL[k]][(j+1)%3]);

                cdf = XW'(prd_reg[k][j][0]) - XW'(prd_reg[k][j][1]);
                abs_next[k][j] = cdf[XW-1] ? AW'(-cdf) : AW'(cdf);

                hi = abs_reg[k][j][AW-1:LW];
                lo = abs_reg[k][j][LW-1:0];
                phh_next[k][j] = (2*HW)'(hi) * (2*HW)'(hi);
                phl_next[k][j] = (HW+LW)'(hi) * (HW+LW)'(lo);
                pll_next[k][j] = (2*LW)'(lo) * (2*LW)'(lo);

                sq_next[k][j] = {phh_reg[k][j], pll_reg[k][j]}
                              + (2*AW)'({phl_reg[k][j], {(LW+1){1'b0}}});
            end
            nrm_next[k] = NW'(sq_reg[k][0]) + NW'(sq_reg[k][1]) + NW'(sq_reg[k][2]);
        end

        // quotient must fit: sub < total * 2^SH, else saturate
        ntsh = {nrm_reg[0], {SH{1'b0}}};
        for (int l = 0; l < 3; l++)
        begin
            nsx         = (NW+SH)'(nrm_reg[l+1]);
            ov0_next[l] = nsx >= ntsh;
            r0_next[l]  = NW'(nrm_reg[l+1] >> SH);
            q0_next[l]  = QW'({nrm_reg[l+1][SH-1:0], {(2*WEIGHT_FRAC_BITS){1'b0}}});
        end
        nt0_next  = nrm_reg[0];
        deg0_next = nrm_reg[0] == '0;

        // restoring divider, one quotient bit per stage
        dv_vld_next = {dv_vld_reg[QW-2:0], fv_reg[FS-1]};
        for (int i = 0; i < QW; i++)
        begin
            if (i == 0)
            begin
                dv_nt_next[i]  = nt0_reg;
                dv_ov_next[i]  = ov0_reg;
                dv_deg_next[i] = deg0_reg;
            end
            else
            begin
                dv_nt_next[i]  = dv_nt_reg[i-1];
                dv_ov_next[i]  = dv_ov_reg[i-1];
                dv_deg_next[i] = dv_deg_reg[i-1];
            end
            for (int l = 0; l < 3; l++)
            begin
                if (i == 0)
                begin
                    rin  = r0_reg[l];
                    qin  = q0_reg[l];
                    ntin = nt0_reg;
                end
                else
                begin
                    rin  = dv_rem_reg[i-1][l];
                    qin  = dv_qx_reg[i-1][l];
                    ntin = dv_nt_reg[i-1];
                end
                dr = {rin, qin[QW-1]};
                ge = dr >= {1'b0, ntin};
                dv_rem_next[i][l] = ge ? NW'(dr - {1'b0, ntin}) : NW'(dr);
                dv_qx_next[i][l]  = {qin[QW-2:0], ge};
            end
        end

        // integer square root, one root bit per stage
        sr_vld_next = {sr_vld_reg[WW-2:0], dv_vld_reg[QW-1]};
        for (int i = 0; i < WW; i++)
        begin
            if (i == 0)
            begin
                sr_ov_next[i]  = dv_ov_reg[QW-1];
                sr_deg_next[i] = dv_deg_reg[QW-1];
            end
            else
            begin
                sr_ov_next[i]  = sr_ov_reg[i-1];
                sr_deg_next[i] = sr_deg_reg[i-1];
            end
            for (int l = 0; l < 3; l++)
            begin
                if (i == 0)
                begin
                    sin  = '0;
                    root = '0;
                    qin  = dv_qx_reg[QW-1][l];
                end
                else
                begin
                    sin  = sr_rem_reg[i-1][l];
                    root = sr_root_reg[i-1][l];
                    qin  = sr_q_reg[i-1][l];
                end
                r2 = {sin, qin[QW-1:QW-2]};
                tr = {1'b0, root, 2'b01};
                ge = r2 >= tr;
                sr_rem_next[i][l]  = ge ? SW'(r2 - tr) : SW'(r2);
                sr_root_next[i][l] = {root[WW-2:0], ge};
                sr_q_next[i][l]    = {qin[QW-3:0], 2'b00};
            end
        end

        for (int l = 0; l < 3; l++)
        begin
            if (sr_deg_reg[WW-1])
                w[l] = '0;
            else if (sr_ov_reg[WW-1][l])
                w[l] = '1;
            else
                w[l] = sr_root_reg[WW-1][l];
        end
        result_next.weight_a   = w[0];
        result_next.weight_b   = w[1];
        result_next.weight_c   = w[2];
        result_next.degenerate = sr_deg_reg[WW-1];
        done_next              = sr_vld_reg[WW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg     <= '0;
            dv_vld_reg <= '0;
            sr_vld_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            fv_reg     <= fv_next;
            dv_vld_reg <= dv_vld_next;
            sr_vld_reg <= sr_vld_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg      <= request;
        dif_reg     <= dif_next;
        prd_reg     <= prd_next;
        abs_reg     <= abs_next;
        phh_reg     <= phh_next;
        phl_reg     <= phl_next;
        pll_reg     <= pll_next;
        sq_reg      <= sq_next;
        nrm_reg     <= nrm_next;
        r0_reg      <= r0_next;
        q0_reg      <= q0_next;
        ov0_reg     <= ov0_next;
        nt0_reg     <= nt0_next;
        deg0_reg    <= deg0_next;
        dv_rem_reg  <= dv_rem_next;
        dv_qx_reg   <= dv_qx_next;
        dv_nt_reg   <= dv_nt_next;
        dv_ov_reg   <= dv_ov_next;
        dv_deg_reg  <= dv_deg_next;
        sr_rem_reg  <= sr_rem_next;
        sr_root_reg <= sr_root_next;
        sr_q_reg    <= sr_q_next;
        sr_ov_reg   <= sr_ov_next;
        sr_deg_reg  <= sr_deg_next;
        result_reg  <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

[verif/barycentric_by_heron_areas_tb.sv]
`timescale 1ns / 100ps

module barycentric_by_heron_areas_tb;

    typedef logic [255:0] big_t;

    typedef struct {
        bary_pkg::req_t req;
        bit             drain_first;
    } pending_t;

    localparam int WFRAC = bary_pkg::WEIGHT_FRAC_BITS_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    bary_pkg::req_t request = '0;
    logic done;
    bary_pkg::res_t result;

    pending_t       pending_q[$];
    bary_pkg::res_t weights_q[$];
    int             n_sent = 0;
    int             n_errors = 0;

    barycentric_by_heron_areas DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // exact squared difference of two coordinates
    function automatic big_t sq_diff(bary_pkg::coord_t p, bary_pkg::coord_t q);
        logic signed [25:0] d;
        big_t m;
        d = p - q;
        m = (d < 0) ? big_t'(-d) : big_t'(d);
        return m * m;
    endfunction

    function automatic big_t dist2(bary_pkg::coord_t ux, bary_pkg::coord_t uy,
                                   bary_pkg::coord_t uz, bary_pkg::coord_t vx,
                                   bary_pkg::coord_t vy, bary_pkg::coord_t vz);
        return sq_diff(ux, vx) + sq_diff(uy, vy) + sq_diff(uz, vz);
    endfunction

    // 16 * area^2 from squared side lengths
    function automatic big_t area16(big_t p, big_t q, big_t r);
        big_t s;
        big_t t;
        big_t t2;
        big_t f;
        s = p + q;
        t = (s >= r) ? s - r : r - s;
        t2 = t * t;
        f = (p * q) << 2;
        return (f >= t2) ? f - t2 : t2 - f;
    endfunction

    function automatic bary_pkg::weight_t area_ratio_root(big_t sub, big_t tot);
        big_t num;
        big_t cand_sq;
        bary_pkg::weight_t w;
        bary_pkg::weight_t cand;
        num = sub << (2 * WFRAC);
        w = '0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = w | (bary_pkg::weight_t'(1) << b);
            cand_sq = big_t'(cand) * big_t'(cand);
            if (cand_sq * tot <= num)
                w = cand;
        end
        return w;
    endfunction

    function automatic bary_pkg::res_t barycentric_weights(bary_pkg::req_t r);
        big_t eab;
        big_t ebc;
        big_t eca;
        big_t dap;
        big_t dbp;
        big_t dcp;
        big_t tot;
        bary_pkg::res_t o;
        eab = dist2(r.ax, r.ay, r.az, r.bx, r.by, r.bz);
        ebc = dist2(r.bx, r.by, r.bz, r.cx, r.cy, r.cz);
        eca = dist2(r.cx, r.cy, r.cz, r.ax, r.ay, r.az);
        dap = dist2(r.ax, r.ay, r.az, r.px, r.py, r.pz);
        dbp = dist2(r.bx, r.by, r.bz, r.px, r.py, r.pz);
        dcp = dist2(r.cx, r.cy, r.cz, r.px, r.py, r.pz);
        tot = area16(eab, ebc, eca);
        o = '0;
        if (tot == 0)
        begin
            o.degenerate = 1'b1;
            return o;
        end
        o.weight_a = area_ratio_root(area16(ebc, dbp, dcp), tot);
        o.weight_b = area_ratio_root(area16(eca, dap, dcp), tot);
        o.weight_c = area_ratio_root(area16(eab, dap, dbp), tot);
        return o;
    endfunction

    task automatic report_mismatch(string what);
        n_errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic bary_pkg::coord_t rnd_span(int span);
        return bary_pkg::coord_t'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic bary_pkg::coord_t rnd_full();
        return bary_pkg::coord_t'($urandom);
    endfunction

    task automatic add_request(bary_pkg::req_t r, bit drain_first);
        pending_t p;
        p.req = r;
        p.drain_first = drain_first;
        pending_q.push_back(p);
    endtask

    function automatic bary_pkg::req_t make_req(
        bary_pkg::coord_t ax, bary_pkg::coord_t ay, bary_pkg::coord_t az,
        bary_pkg::coord_t bx, bary_pkg::coord_t by, bary_pkg::coord_t bz,
        bary_pkg::coord_t cx, bary_pkg::coord_t cy, bary_pkg::coord_t cz,
        bary_pkg::coord_t px, bary_pkg::coord_t py, bary_pkg::coord_t pz);
        bary_pkg::req_t r;
        r.ax = ax; r.ay = ay; r.az = az;
        r.bx = bx; r.by = by; r.bz = bz;
        r.cx = cx; r.cy = cy; r.cz = cz;
        r.px = px; r.py = py; r.pz = pz;
        return r;
    endfunction

    // sender side; idle rate moves with the number of requests sent
    always @(posedge clk or negedge rst_n)
    begin
        int idle_pct;
        bit taken;
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                weights_q.push_back(barycentric_weights(request));
                void'(pending_q.pop_front());
                n_sent++;
            end
            if (!start || taken)
            begin
                idle_pct = (n_sent < 275) ? 18 : (n_sent < 525) ? 86 : 0;
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct &&
                    !(pending_q[0].drain_first && weights_q.size() > 0))
                begin
                    start <= 1'b1;
                    request <= pending_q[0].req;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        bary_pkg::res_t want;
        if (rst_n && done)
        begin
            if (weights_q.size() == 0)
                report_mismatch("result with none expected");
            else
            begin
                want = weights_q.pop_front();
                if (result.weight_a !== want.weight_a)
                    report_mismatch($sformatf("weight_a %h want %h",
                                              result.weight_a, want.weight_a));
                if (result.weight_b !== want.weight_b)
                    report_mismatch($sformatf("weight_b %h want %h",
                                              result.weight_b, want.weight_b));
                if (result.weight_c !== want.weight_c)
                    report_mismatch($sformatf("weight_c %h want %h",
                                              result.weight_c, want.weight_c));
                if (result.degenerate !== want.degenerate)
                    report_mismatch($sformatf("degenerate %b want %b",
                                              result.degenerate, want.degenerate));
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        bary_pkg::coord_t mx;
        bary_pkg::coord_t mn;
        bary_pkg::coord_t s;
        bary_pkg::coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
        int k;
        int span;
        mx = bary_pkg::coord_t'(24'h7FFFFF);
        mn = bary_pkg::coord_t'(24'h800000);
        s = bary_pkg::coord_t'(1);

        // directed
        add_request(make_req(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx), 0);
        add_request(make_req(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn), 0);
        add_request(make_req(mn, mn, mn, mx, mn, mn, mn, mx, mn, mn, mn, mx), 0);
        add_request(make_req(mx, mx, mx, mn, mx, mx, mx, mn, mx, mn, mn, mn), 0);
        add_request(make_req(mn, mn, 0, mx, mn, 0, mn, mx, 0, 0, 0, 0), 0);
        add_request(make_req(0, 0, 0, s, 0, 0, 0, s, 0, 0, 0, 0), 0);
        add_request(make_req(0, 0, 0, s, 0, 0, 0, s, 0, s, 0, 0), 0);
        add_request(make_req(0, 0, 0, s, 0, 0, 0, s, 0, 0, s, 0), 0);
        add_request(make_req(0, 0, 0, s, 0, 0, 0, s, 0, mx, mx, mx), 0);
        add_request(make_req(0, 0, 0, s, 0, 0, 0, s, 0, mn, mn, mn), 0);
        add_request(make_req(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 1024, 1024, 0), 0);
        add_request(make_req(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 1024, 1024, 777), 0);
        add_request(make_req(0, 0, 0, 4096, 0, 0, 0, 4096, 0, -4096, -4096, 0), 0);
        add_request(make_req(5, 5, 5, 5, 5, 5, 5, 5, 5, 9, 9, 9), 0);
        add_request(make_req(0, 0, 0, 10, 10, 10, 20, 20, 20, 3, 4, 5), 0);
        add_request(make_req(0, 0, 0, 10, 10, 10, 0, 0, 0, 3, 4, 5), 0);
        add_request(make_req(mn, 0, 0, mx, 0, 0, 0, 0, 0, 0, mx, 0), 0);
        add_request(make_req(mn, mn, mn, mx, mx, mx, mn, mx, 0, mx, mn, 0), 0);
        add_request(make_req(mn, 0, 0, mx, 0, 0, 0, mn, 0, 0, mx, mx), 0);
        add_request(make_req(100, -200, 300, -400, 500, -600, 700, -800, 900,
                             0, 0, 0), 0);

        // random
        for (int i = 0; i < 740; i++)
        begin
            k = $urandom_range(0, 99);
            span = ($urandom_range(0, 3) == 0) ? 8388607 : (1 << $urandom_range(2, 20));
            if (k < 10)
                add_request(make_req(rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                                     rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                                     rnd_full(), rnd_full(), rnd_full(), rnd_full()),
                            i == 0 || i == 260 || i == 510);
            else
            begin
                ax = rnd_span(span); ay = rnd_span(span); az = rnd_span(span);
                bx = rnd_span(span); by = rnd_span(span); bz = rnd_span(span);
                cx = rnd_span(span); cy = rnd_span(span); cz = rnd_span(span);
                if (k < 18)
                begin
                    // collinear or coincident vertices
                    cx = ax + (bx - ax) * $urandom_range(0, 2);
                    cy = ay + (by - ay) * $urandom_range(0, 2);
                    cz = az + (bz - az) * $urandom_range(0, 2);
                    if (k < 12)
                    begin
                        cx = ax; cy = ay; cz = az;
                    end
                end
                else if (k < 28)
                begin
                    // tiny triangle, distant point
                    bx = ax + rnd_span(3); by = ay + rnd_span(3); bz = az;
                    cx = ax + rnd_span(3); cy = ay + rnd_span(3); cz = az + rnd_span(3);
                end
                if (k >= 28 && k < 60)
                    add_request(make_req(ax, ay, az, bx, by, bz, cx, cy, cz,
                                         ax + (bx - ax) / 3 + (cx - ax) / 3,
                                         ay + (by - ay) / 3 + (cy - ay) / 3,
                                         az + (bz - az) / 3 + (cz - az) / 3),
                                i == 0 || i == 260 || i == 510);
                else
                    add_request(make_req(ax, ay, az, bx, by, bz, cx, cy, cz,
                                         rnd_span(span), rnd_span(span), rnd_span(span)),
                                i == 0 || i == 260 || i == 510);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && weights_q.size() == 0);
        repeat (120) @(posedge clk);
        if (weights_q.size() != 0)
            report_mismatch("results still expected at end");
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
